// ===== rtl/arpc_pkg.sv =====
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int IP_W        = 32;
    localparam int MAC_W       = 48;
    localparam int IDX_OUT_W   = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_ADD    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ACT_LOOKUP  = 2'd0,
        ACT_UPDATE  = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_REPLACE = 2'd3
    } act_t;

    typedef struct packed
    {
        op_t              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } cmd_t;

    typedef struct packed
    {
        logic                 hit;
        logic [MAC_W-1:0]     mac;
        act_t                 action;
        logic [IDX_OUT_W-1:0] index;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/arpc_front.sv =====
`default_nettype none

module arpc_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         mode,
    input  wire logic [arpc_pkg::IP_W-1:0]    ip_address,
    input  wire logic [arpc_pkg::MAC_W-1:0]   mac_address,
    output logic                              cmd_valid,
    output arpc_pkg::cmd_t                    cmd,
    input  wire logic                         cmd_pop
);
    import arpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;
    cmd_t             cmd_in;

    // classify the incoming transaction into an engine command
    always_comb
    begin
        cmd_in.op  = op_t'(mode);
        cmd_in.ip  = ip_address;
        cmd_in.mac = mac_address;
    end

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/arpc_engine.sv =====
`default_nettype none

module arpc_engine
#(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire arpc_pkg::cmd_t cmd,
    output logic                cmd_pop,
    input  wire logic           pop,
    output logic                res_valid,
    output arpc_pkg::res_t      res
);
    import arpc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [3:0]
    {
        S_IDLE    = 4'b0001,
        S_MATCH   = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_READ    = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    cmd_t                          cmd_reg;
    logic [ENTRIES-1:0]            valid_reg;
    logic [ENTRIES-1:0]            match_reg;
    logic [IP_W-1:0]               ip_reg [ENTRIES];
    logic [MAC_W-1:0]              mac_mem [ENTRIES];
    logic [MAC_W-1:0]              mac_rd_reg;
    logic                          out_valid_reg, out_valid_next;
    res_t                          res_reg, res_next;

    logic [ENTRIES-1:0]            match_vec;
    logic [ENTRIES-1:0]            match_low;
    logic [ENTRIES-1:0]            free_vec;
    logic [ENTRIES-1:0]            free_low;
    logic                          match_any;
    logic                          free_any;
    logic [IDX_W-1:0]              match_idx;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              wr_idx;
    logic [IDX_W-1:0]              sel_idx;
    logic [IDX_W+IDX_OUT_W-1:0]    idx_ext;
    logic                          is_add;
    logic                          wr_en;
    logic                          rd_en;

    // parallel compare across all cam cells
    always_comb
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            match_vec[k] = valid_reg[k] && (ip_reg[k] == cmd_reg.ip);
        end
    end

    // isolate lowest set bit, then encode the one-hot vector
    assign free_vec  = ~valid_reg;
    assign match_low = match_reg & (~match_reg + ENTRIES'(1));
    assign free_low  = free_vec & (~free_vec + ENTRIES'(1));
    assign match_any = |match_reg;
    assign free_any  = |free_vec;

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (match_low[k])
            begin
                match_idx = match_idx | IDX_W'(k);
            end
            if (free_low[k])
            begin
                free_idx = free_idx | IDX_W'(k);
            end
        end
    end

    assign is_add = (cmd_reg.op == OP_ADD);
    assign wr_idx = match_any ? match_idx : (free_any ? free_idx : '0);
    assign wr_en  = (state_reg == S_RESOLVE) && is_add;
    assign rd_en  = (state_reg == S_RESOLVE) && !is_add && match_any;

    assign sel_idx = is_add ? wr_idx : (match_any ? match_idx : '0);
    assign idx_ext = {{IDX_OUT_W{1'b0}}, sel_idx};

    always_comb
    begin
        state_next     = state_reg;
        cmd_pop        = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        res_next       = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (rd_en)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    res_next.hit   = 1'b0;
                    res_next.mac   = '0;
                    res_next.index = idx_ext[IDX_OUT_W-1:0];
                    if (!is_add)
                    begin
                        res_next.action = ACT_LOOKUP;
                    end
                    else if (match_any)
                    begin
                        res_next.action = ACT_UPDATE;
                    end
                    else if (free_any)
                    begin
                        res_next.action = ACT_FILL;
                    end
                    else
                    begin
                        res_next.action = ACT_REPLACE;
                    end
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                out_valid_next  = 1'b1;
                res_next.hit    = 1'b1;
                res_next.mac    = mac_rd_reg;
                res_next.action = ACT_LOOKUP;
                res_next.index  = idx_ext[IDX_OUT_W-1:0];
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_MATCH)
        begin
            match_reg <= match_vec;
        end
        if (wr_en)
        begin
            ip_reg[wr_idx] <= cmd_reg.ip;
        end
        res_reg <= res_next;
    end

    // mac store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mac_mem[wr_idx] <= cmd_reg.mac;
        end
        if (rd_en)
        begin
            mac_rd_reg <= mac_mem[match_idx];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    // stored addresses stay unique, so at most one entry can match
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESOLVE) |-> $onehot0(match_reg))
        else $error("more than one valid entry matches");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("valid mark dropped");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_READ) || ((state_reg == S_RESOLVE) && !rd_en)) |-> !out_valid_reg)
        else $error("result produced while output still occupied");

    a_read_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> ($past(state_reg) == S_RESOLVE) && !is_add)
        else $error("mac read state entered without a lookup hit");

endmodule

`default_nettype wire

// ===== rtl/arp_cache_table.sv =====
`default_nettype none

// ARP cache: a register-based CAM of ENTRIES slots mapping IPv4 to MAC addresses.
// Each transaction is a lookup (mode 0) or an add/update (mode 1) and yields one
// result. A two-entry command queue in front takes transactions while the engine
// works, so push is held off only when that queue is full. The engine handles one
// command at a time: an add or a lookup miss passes through dequeue, parallel
// address compare, and priority select and write; a lookup hit takes an extra
// read step because the MAC comes from a memory with a registered read port. A
// result waits in the output register until popped, and the engine starts the next
// command only once that register is free. Valid marks are cleared at reset; there
// is no clearing pass.
module arp_cache_table
#(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             mode,
    input  wire logic [arpc_pkg::IP_W-1:0]        ip_address,
    input  wire logic [arpc_pkg::MAC_W-1:0]       mac_address,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic                                  hit,
    output logic [arpc_pkg::MAC_W-1:0]            mac_out,
    output logic [1:0]                            action,
    output logic [arpc_pkg::IDX_OUT_W-1:0]        entry_index
);
    import arpc_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;
    logic res_valid;
    res_t res;

    arpc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .ip_address  (ip_address),
        .mac_address (mac_address),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    arpc_engine #(.ENTRIES(ENTRIES)) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty       = !res_valid;
    assign hit         = res.hit;
    assign mac_out     = res.mac;
    assign action      = res.action;
    assign entry_index = res.index;

endmodule

`default_nettype wire
